FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mtep_pkg.sv
// Package for the MIDI track event parser: parser state, result layout, codes.
// No dependencies; used by mtep_core and midi_track_event_parser.
package mtep_pkg;

    // Parse phases, one-hot
    typedef enum logic [8:0] {
        PH_HEADER    = 9'b000000001,
        PH_DELTA     = 9'b000000010,
        PH_STATUS    = 9'b000000100,
        PH_META_TYPE = 9'b000001000,
        PH_META_LEN  = 9'b000010000,
        PH_META_DATA = 9'b000100000,
        PH_NOTE_NUM  = 9'b001000000,
        PH_NOTE_VEL  = 9'b010000000,
        PH_DONE      = 9'b100000000
    } phase_t;

    // Event kinds
    localparam logic [3:0] KIND_NOTE_ON     = 4'd0;
    localparam logic [3:0] KIND_NOTE_OFF    = 4'd1;
    localparam logic [3:0] KIND_TEMPO       = 4'd2;
    localparam logic [3:0] KIND_END         = 4'd3;
    localparam logic [3:0] KIND_LYRICS      = 4'd4;
    localparam logic [3:0] KIND_META_IGNORE = 4'd5;
    localparam logic [3:0] KIND_META_OTHER  = 4'd6;
    localparam logic [3:0] KIND_BAD_STATUS  = 4'd7;
    localparam logic [3:0] KIND_BAD_HEADER  = 4'd8;
    localparam logic [3:0] KIND_BAD_TEMPO   = 4'd9;
    localparam logic [3:0] KIND_EMPTY       = 4'd10;

    // Content flag bits
    localparam int FL_TEMPO  = 0;
    localparam int FL_NOTES  = 1;
    localparam int FL_LYRICS = 2;
    localparam int FL_OTHER  = 3;
    localparam int FL_END    = 4;

    // Byte codes
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_END      = 8'h2F;
    localparam logic [7:0] META_LYRIC    = 8'h05;
    localparam logic [7:0] META_TIME_SIG = 8'h58;
    localparam logic [7:0] META_TEXT     = 8'h01;
    localparam logic [7:0] META_NAME     = 8'h03;
    localparam logic [7:0] STAT_META     = 8'hFF;
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [7:0] TEMPO_LEN     = 8'd3;

    // "MTrk", element 0 is the first byte
    localparam logic [3:0][7:0] MTRK_TAG = {8'h6B, 8'h72, 8'h54, 8'h4D};

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  header_index;
        logic        tag_ok;
        logic [31:0] chunk_length;
        logic [31:0] bytes_counted;
        logic [27:0] delta_accum;
        logic [1:0]  delta_bytes;
        logic [31:0] tick_total;
        logic [7:0]  running_status;
        logic [7:0]  current_status;
        logic [7:0]  meta_type;
        logic [7:0]  meta_length;
        logic [7:0]  meta_remaining;
        logic [23:0] tempo_accum;
        logic [7:0]  held_note;
        logic [4:0]  flags_seen;
        logic [7:0]  max_note;
        logic [7:0]  min_note;
    } parse_st_t;

    localparam parse_st_t ST_RESET = '{
        phase:          PH_HEADER,
        header_index:   3'd0,
        tag_ok:         1'b1,
        chunk_length:   32'd0,
        bytes_counted:  32'd0,
        delta_accum:    28'd0,
        delta_bytes:    2'd0,
        tick_total:     32'd0,
        running_status: 8'd0,
        current_status: 8'd0,
        meta_type:      8'd0,
        meta_length:    8'd0,
        meta_remaining: 8'd0,
        tempo_accum:    24'd0,
        held_note:      8'd0,
        flags_seen:     5'd0,
        max_note:       8'd0,
        min_note:       8'hFF
    };

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [31:0] elapsed_ticks;
        logic [7:0]  note_number;
        logic [7:0]  velocity;
        logic [23:0] tempo_value;
        logic [4:0]  content_flags;
        logic [7:0]  highest_note;
        logic [7:0]  lowest_note;
        logic        track_done;
    } result_t;

    // Core status toward the top level
    typedef struct packed {
        logic res_valid;
        logic parse_done;
    } core_stat_t;

endpackage

FILE: rtl/mtep_core.sv
// Parser core: holds the parse state and decodes one track byte per transfer.
// Depends on mtep_pkg.
module mtep_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_take,
    input  logic [7:0]           data_byte,
    input  logic                 track_start,
    output mtep_pkg::result_t    res,
    output mtep_pkg::core_stat_t stat
);
    import mtep_pkg::*;

    parse_st_t st_reg;
    parse_st_t st_next;

    parse_st_t   cur;
    logic [31:0] cnt_inc;
    logic        fin;
    logic        meta_fin;
    logic        stop;
    logic        done;
    logic [3:0]  kind;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [23:0] tempo;

    // Next-state and result decode
    always_comb begin
        cur      = track_start ? ST_RESET : st_reg;
        st_next  = cur;
        cnt_inc  = (cur.bytes_counted == 32'hFFFF_FFFF) ? cur.bytes_counted
                                                          : cur.bytes_counted + 32'd1;
        fin      = 1'b0;
        meta_fin = 1'b0;
        stop     = 1'b0;
        kind     = KIND_NOTE_ON;
        note     = 8'd0;
        vel      = 8'd0;
        tempo    = 24'd0;

        case (cur.phase)
            PH_HEADER: begin
                if (!cur.header_index[2]) begin
                    if (data_byte != MTRK_TAG[cur.header_index[1:0]]) begin
                        st_next.tag_ok = 1'b0;
                    end
                end else begin
                    st_next.chunk_length = {cur.chunk_length[23:0], data_byte};
                end
                if (cur.header_index == 3'd7) begin
                    st_next.header_index = 3'd0;
                    if (!st_next.tag_ok) begin
                        fin  = 1'b1;
                        stop = 1'b1;
                        kind = KIND_BAD_HEADER;
                    end else if (st_next.chunk_length == 32'd0) begin
                        fin  = 1'b1;
                        stop = 1'b1;
                        kind = KIND_EMPTY;
                    end else begin
                        st_next.phase       = PH_DELTA;
                        st_next.delta_accum = 28'd0;
                        st_next.delta_bytes = 2'd0;
                    end
                end else begin
                    st_next.header_index = cur.header_index + 3'd1;
                end
            end
            PH_DELTA: begin
                st_next.bytes_counted = cnt_inc;
                st_next.delta_accum   = {cur.delta_accum[20:0], data_byte[6:0]};
                if (data_byte[7] && cur.delta_bytes != 2'd3) begin
                    st_next.delta_bytes = cur.delta_bytes + 2'd1;
                end else begin
                    st_next.tick_total  = cur.tick_total + {4'd0, st_next.delta_accum};
                    st_next.delta_bytes = 2'd0;
                    st_next.phase       = PH_STATUS;
                end
            end
            PH_STATUS: begin
                st_next.bytes_counted = cnt_inc;
                if (data_byte == STAT_META) begin
                    st_next.running_status = data_byte;
                    st_next.phase          = PH_META_TYPE;
                end else if (data_byte[7:5] == 3'b100) begin
                    st_next.running_status = data_byte;
                    st_next.current_status = data_byte;
                    st_next.phase          = PH_NOTE_NUM;
                end else if (!data_byte[7]) begin
                    // running status: this byte is the note number
                    st_next.held_note      = data_byte;
                    st_next.current_status = cur.running_status;
                    st_next.phase          = PH_NOTE_VEL;
                end else begin
                    st_next.running_status       = data_byte;
                    st_next.flags_seen[FL_OTHER] = 1'b1;
                    fin  = 1'b1;
                    kind = KIND_BAD_STATUS;
                end
            end
            PH_META_TYPE: begin
                st_next.bytes_counted = cnt_inc;
                st_next.meta_type     = data_byte;
                st_next.phase         = PH_META_LEN;
            end
            PH_META_LEN: begin
                st_next.bytes_counted  = cnt_inc;
                st_next.meta_length    = data_byte;
                st_next.meta_remaining = data_byte;
                st_next.tempo_accum    = 24'd0;
                if (data_byte == 8'd0) begin
                    meta_fin = 1'b1;
                end else begin
                    st_next.phase = PH_META_DATA;
                end
            end
            PH_META_DATA: begin
                st_next.bytes_counted  = cnt_inc;
                st_next.tempo_accum    = {cur.tempo_accum[15:0], data_byte};
                st_next.meta_remaining = cur.meta_remaining - 8'd1;
                if (st_next.meta_remaining == 8'd0) begin
                    meta_fin = 1'b1;
                end
            end
            PH_NOTE_NUM: begin
                st_next.bytes_counted = cnt_inc;
                st_next.held_note     = data_byte;
                st_next.phase         = PH_NOTE_VEL;
            end
            PH_NOTE_VEL: begin
                st_next.bytes_counted        = cnt_inc;
                st_next.flags_seen[FL_NOTES] = 1'b1;
                fin  = 1'b1;
                note = cur.held_note;
                vel  = data_byte;
                if (cur.current_status[7:4] == STAT_NOTE_OFF || data_byte == 8'd0) begin
                    kind = KIND_NOTE_OFF;
                end else if (cur.current_status[7:4] == STAT_NOTE_ON) begin
                    kind = KIND_NOTE_ON;
                    if (cur.held_note > cur.max_note) begin
                        st_next.max_note = cur.held_note;
                    end
                    if (cur.held_note < cur.min_note) begin
                        st_next.min_note = cur.held_note;
                    end
                end else begin
                    kind = KIND_BAD_STATUS;
                end
            end
            default: begin
                // track finished: bytes dropped until the next track start
            end
        endcase

        // Meta event completion
        if (meta_fin) begin
            fin = 1'b1;
            if (st_next.meta_type == META_TEMPO && st_next.meta_length != TEMPO_LEN) begin
                stop = 1'b1;
                kind = KIND_BAD_TEMPO;
            end else begin
                case (st_next.meta_type)
                    META_TEMPO: begin
                        kind  = KIND_TEMPO;
                        tempo = st_next.tempo_accum;
                        st_next.flags_seen[FL_TEMPO] = 1'b1;
                    end
                    META_END: begin
                        kind = KIND_END;
                        st_next.flags_seen[FL_END] = 1'b1;
                    end
                    META_LYRIC: begin
                        kind = KIND_LYRICS;
                        st_next.flags_seen[FL_LYRICS] = 1'b1;
                    end
                    META_TIME_SIG, META_TEXT, META_NAME: begin
                        kind = KIND_META_IGNORE;
                    end
                    default: begin
                        kind = KIND_META_OTHER;
                        st_next.flags_seen[FL_OTHER] = 1'b1;
                    end
                endcase
            end
        end

        // Event completion: length check and phase change
        done = stop || (st_next.bytes_counted >= st_next.chunk_length);
        if (fin) begin
            if (done) begin
                st_next.phase = PH_DONE;
            end else begin
                st_next.phase       = PH_DELTA;
                st_next.delta_accum = 28'd0;
                st_next.delta_bytes = 2'd0;
            end
        end

        res.event_kind    = kind;
        res.elapsed_ticks = st_next.tick_total;
        res.note_number   = note;
        res.velocity      = vel;
        res.tempo_value   = tempo;
        res.content_flags = st_next.flags_seen;
        res.highest_note  = st_next.max_note;
        res.lowest_note   = st_next.min_note;
        res.track_done    = done;
        stat.res_valid    = fin;
        stat.parse_done   = (st_reg.phase == PH_DONE);
    end

    // State register, advanced on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (byte_take) begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: stream ports, result register, checks.
// Depends on mtep_pkg, mtep_core and assert_macros.svh.
//
//   channel   dir  tdata                      side band
//   s_        in   data_byte                  tuser = track_start
//   m_        out  event fields (104 bits)    tlast = track_done
//
// One byte per cycle while s_tready is high; each byte is decoded in the same cycle it is taken.
// A result appears in m_ the cycle after the byte that completes an event.
// The single result register gates input: s_tready is low only while a
// result waits and m_tready is low. Reset (aresetn low, synchronous) clears
// the parser to the header phase and empties the result register.
`include "assert_macros.svh"

module midi_track_event_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tuser,   // [0] track_start
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // [3:0] event_kind, [35:4] elapsed_ticks,
                                     // [43:36] note_number, [51:44] velocity,
                                     // [75:52] tempo_value, [80:76] content_flags,
                                     // [88:81] highest_note, [96:89] lowest_note,
                                     // [103:97] zero
    output logic          m_tlast    // track_done
);
    import mtep_pkg::*;

    logic       byte_take;
    result_t    core_res;
    core_stat_t core_stat;

    logic    m_valid_reg;
    logic    m_valid_next;
    result_t m_res_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;

    mtep_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_take   (byte_take),
        .data_byte   (s_tdata),
        .track_start (s_tuser),
        .res         (core_res),
        .stat        (core_stat)
    );

    // Result register
    always_comb begin
        if (byte_take) begin
            m_valid_next = core_stat.res_valid;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_take && core_stat.res_valid) begin
            m_res_reg <= core_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.track_done;
    assign m_tdata  = {7'd0,
                       m_res_reg.lowest_note,
                       m_res_reg.highest_note,
                       m_res_reg.content_flags,
                       m_res_reg.tempo_value,
                       m_res_reg.velocity,
                       m_res_reg.note_number,
                       m_res_reg.elapsed_ticks,
                       m_res_reg.event_kind};

    // Checks
    `ASSERT_IMP(a_err_ends_track, core_stat.res_valid && (core_res.event_kind == KIND_BAD_HEADER || core_res.event_kind == KIND_BAD_TEMPO || core_res.event_kind == KIND_EMPTY), core_res.track_done, "error result without track end")
    `ASSERT_NXT(a_done_stops, byte_take && core_stat.res_valid && core_res.track_done, core_stat.parse_done, "parser still running after track end")
    `ASSERT_IMP(a_note_range, core_stat.res_valid && core_res.event_kind == KIND_NOTE_ON, core_res.lowest_note <= core_res.highest_note, "note range inverted after note on")
    `ASSERT_IMP(a_ready_empty, !m_valid_reg, s_tready, "input stalled with empty result register")

endmodule
